// ===== hw/rtl/rtht_pkg.sv =====
`timescale 1ns / 1ps

package rtht_pkg;

  localparam int NUM_BUCKETS_DEF = 512;
  localparam int WAYS_DEF        = 4;
  localparam int STAMP_BITS_DEF  = 24;

  localparam int HASH_BITS = 64;
  localparam int TAG_BITS  = 32;
  localparam int FOLD_BITS = 16;
  localparam int REP_BITS  = 8;

  function automatic logic [TAG_BITS-1:0] fold_tag(input logic [HASH_BITS-1:0] h);
    fold_tag = h[TAG_BITS-1:0] ^ h[HASH_BITS-1:TAG_BITS];
  endfunction

  function automatic logic [FOLD_BITS-1:0] fold_short(input logic [TAG_BITS-1:0] t);
    fold_short = t[FOLD_BITS-1:0] ^ t[TAG_BITS-1:FOLD_BITS];
  endfunction

endpackage

// ===== hw/rtl/rtht_row_mem.sv =====
`timescale 1ns / 1ps

module rtht_row_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 256,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rtht_bucket_index.sv =====
`timescale 1ns / 1ps

module rtht_bucket_index
  import rtht_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int BKT_W       = 9
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [FOLD_BITS-1:0] fold,
  output logic [BKT_W-1:0]     bucket
);

  // fold mod N via ceil(2^32/N) reciprocal; exact for 16-bit folds
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << 32) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];
  localparam logic [FOLD_BITS:0] NB = (FOLD_BITS+1)'(NUM_BUCKETS);

  logic [FOLD_BITS-1:0]    fold_q;
  logic [FOLD_BITS+31:0]   prod;
  logic [FOLD_BITS-1:0]    quot;
  logic [2*FOLD_BITS:0]    qn;
  logic [FOLD_BITS-1:0]    rem;

  always_ff @(posedge clk) begin
    if (load) begin
      fold_q <= fold;
      prod   <= {32'd0, fold} * {{FOLD_BITS{1'b0}}, RECIP};
    end
  end

  always_comb begin
    quot   = prod[FOLD_BITS+31:32];
    qn     = {{(FOLD_BITS+1){1'b0}}, quot} * {{FOLD_BITS{1'b0}}, NB};
    rem    = fold_q - qn[FOLD_BITS-1:0];
    bucket = rem[BKT_W-1:0];
  end

endmodule

// ===== hw/rtl/rtht_way_pick.sv =====
`timescale 1ns / 1ps

module rtht_way_pick
  import rtht_pkg::*;
#(
  parameter int WAYS       = WAYS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  parameter int ENT_W      = TAG_BITS + STAMP_BITS + REP_BITS,
  parameter int ROW_W      = WAYS * ENT_W
) (
  input  logic [ROW_W-1:0]      row,
  input  logic [TAG_BITS-1:0]   tag,
  input  logic [STAMP_BITS-1:0] seq,
  output logic [ROW_W-1:0]      new_row,
  output logic [REP_BITS-1:0]   repeat_count
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [ENT_W-1:0]      ent;
  logic [TAG_BITS-1:0]   e_tag;
  logic [STAMP_BITS-1:0] e_stamp;
  logic [REP_BITS-1:0]   e_rep;
  logic [STAMP_BITS-1:0] age;
  logic [STAMP_BITS-1:0] oldest;
  logic [WAY_W-1:0]      victim;
  logic [WAY_W-1:0]      hit_way;
  logic                  hit;
  logic [REP_BITS-1:0]   hit_rep;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    hit_rep = '0;
    oldest  = '0;
    victim  = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent     = row[w*ENT_W +: ENT_W];
      e_tag   = ent[ENT_W-1 -: TAG_BITS];
      e_stamp = ent[REP_BITS +: STAMP_BITS];
      e_rep   = ent[REP_BITS-1:0];
      age     = seq - e_stamp;
      if (!hit && e_tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
        hit_rep = e_rep + 8'd1;
      end
      if (age > oldest) begin
        oldest = age;
        victim = WAY_W'(w);
      end
    end

    new_row = row;
    for (int w = 0; w < WAYS; w++) begin
      ent = row[w*ENT_W +: ENT_W];
      if (hit && hit_way == WAY_W'(w)) begin
        new_row[w*ENT_W +: ENT_W] = {ent[ENT_W-1 -: TAG_BITS], seq, hit_rep};
      end else if (!hit && victim == WAY_W'(w)) begin
        new_row[w*ENT_W +: ENT_W] = {tag, seq, {REP_BITS{1'b0}}};
      end
    end

    repeat_count = hit ? hit_rep : '0;
  end

endmodule

// ===== hw/rtl/repeat_tracking_hash_table_core.sv =====
`timescale 1ns / 1ps

// Channel   Ports                       Handshake
// input     pkt_hash                    start & !busy
// result    repeat_count, hash_echo     done (one cycle)
//
// An item passes through fold and reciprocal multiply, bucket index and row read,
// then compare and row write-back. The single row memory port pair sets this order.
// After reset a clearing pass zeroes NUM_BUCKETS rows, one per cycle, with
// busy high. The result register lets done coincide with the next accept;
// results cannot be stalled.

module repeat_tracking_hash_table_core
  import rtht_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [HASH_BITS-1:0] pkt_hash,
  output logic                 busy,
  output logic                 done,
  output logic [REP_BITS-1:0]  repeat_count,
  output logic [HASH_BITS-1:0] hash_echo
);

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int ENT_W = TAG_BITS + STAMP_BITS + REP_BITS;
  localparam int ROW_W = WAYS * ENT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_LOOKUP
  } state_t;

  state_t                state;
  logic [BKT_W-1:0]      clr_addr;
  logic [STAMP_BITS-1:0] seq;
  logic [HASH_BITS-1:0]  hash_q;
  logic [BKT_W-1:0]      bucket_q;

  logic                  accept;
  logic [BKT_W-1:0]      bucket;
  logic                  mem_we;
  logic [BKT_W-1:0]      mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic [ROW_W-1:0]      mem_rdata;
  logic [ROW_W-1:0]      new_row;
  logic [REP_BITS-1:0]   rep_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  rtht_bucket_index #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .BKT_W      (BKT_W)
  ) u_index (
    .clk   (clk),
    .load  (accept),
    .fold  (fold_short(fold_tag(pkt_hash))),
    .bucket(bucket)
  );

  rtht_row_mem #(
    .DEPTH(NUM_BUCKETS),
    .WIDTH(ROW_W),
    .AW   (BKT_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (state == ST_INDEX),
    .raddr(bucket),
    .rdata(mem_rdata)
  );

  rtht_way_pick #(
    .WAYS      (WAYS),
    .STAMP_BITS(STAMP_BITS),
    .ENT_W     (ENT_W),
    .ROW_W     (ROW_W)
  ) u_pick (
    .row         (mem_rdata),
    .tag         (fold_tag(hash_q)),
    .seq         (seq),
    .new_row     (new_row),
    .repeat_count(rep_next)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bucket_q;
    mem_wdata = new_row;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_LOOKUP: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      seq      <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BKT_W'(NUM_BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            hash_q <= pkt_hash;
            seq    <= seq + 1'b1;
            state  <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          bucket_q <= bucket;
          state    <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          done         <= 1'b1;
          repeat_count <= rep_next;
          hash_echo    <= hash_q;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
